@@ sv/mrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_pkg: shared types and constants of the response deframer
// Command codes passed from the parser to the checker, report kinds, frame
// status codes, register indexes and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mrd_pkg;

  // Register indexes on the configuration port
  localparam logic REG_STATION  = 1'b0;
  localparam logic REG_FUNCTION = 1'b1;

  // Register reset values
  localparam logic [7:0] RESET_STATION  = 8'h01;
  localparam logic [7:0] RESET_FUNCTION = 8'h03;

  // CRC-16 parameters: init all ones, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Payload signature bytes
  localparam logic [7:0] SIG_ANCHOR = 8'hCA;
  localparam logic [7:0] SIG_TAG    = 8'hAC;
  localparam logic [7:0] SIG_SECOND = 8'hDA;

  // Report kinds
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_ANCHOR = 2'd1;
  localparam logic [1:0] KIND_TAG    = 2'd2;

  // Frame status codes
  localparam logic [1:0] STATUS_PENDING = 2'd0;
  localparam logic [1:0] STATUS_GOOD    = 2'd1;
  localparam logic [1:0] STATUS_BAD     = 2'd2;

  // Work passed from parser to checker
  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_FUNC    = 3'd1,
    CMD_COUNT   = 3'd2,
    CMD_PAYLOAD = 3'd3,
    CMD_CHK_LO  = 3'd4,
    CMD_CHK_HI  = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic [7:0] index;
  } entry_t;

  // Fold one byte into the CRC, least significant bit first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/mrd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_front: frame parser
// Holds the configuration registers, hunts for address and function code,
// tracks the byte count and payload position, and tags each byte with the
// work the checker must do on it.
// ----------------------------------------------------------------------------
module mrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output mrd_pkg::entry_t   q_entry
);

  typedef enum logic [2:0] {
    ST_ADDR,
    ST_FUNC,
    ST_COUNT,
    ST_PAYLOAD,
    ST_CHK_LO,
    ST_CHK_HI
  } state_t;

  state_t     state, state_next;
  logic [7:0] station_address;
  logic [7:0] function_code;
  logic [7:0] length;
  logic [7:0] position;
  logic [7:0] position_inc;
  logic       accept;

  assign accept       = push && !q_full;
  assign position_inc = position + 8'd1;

  // Classify the incoming byte and pick the next phase
  always_comb begin
    state_next    = state;
    q_push        = 1'b0;
    q_entry.cmd   = mrd_pkg::CMD_START;
    q_entry.data  = rx_byte;
    q_entry.index = position;
    if (accept) begin
      unique case (state)
        ST_FUNC: begin
          if (rx_byte == function_code) begin
            q_push      = 1'b1;
            q_entry.cmd = mrd_pkg::CMD_FUNC;
            state_next  = ST_COUNT;
          end else if (rx_byte == station_address) begin
            q_push     = 1'b1;
            state_next = ST_FUNC;
          end else begin
            state_next = ST_ADDR;
          end
        end
        ST_COUNT: begin
          q_push      = 1'b1;
          q_entry.cmd = mrd_pkg::CMD_COUNT;
          state_next  = (rx_byte == 8'd0) ? ST_CHK_LO : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          q_push      = 1'b1;
          q_entry.cmd = mrd_pkg::CMD_PAYLOAD;
          if (position_inc == length) begin
            state_next = ST_CHK_LO;
          end
        end
        ST_CHK_LO: begin
          q_push      = 1'b1;
          q_entry.cmd = mrd_pkg::CMD_CHK_LO;
          state_next  = ST_CHK_HI;
        end
        ST_CHK_HI: begin
          q_push      = 1'b1;
          q_entry.cmd = mrd_pkg::CMD_CHK_HI;
          state_next  = ST_ADDR;
        end
        default: begin
          if (rx_byte == station_address) begin
            q_push     = 1'b1;
            state_next = ST_FUNC;
          end else begin
            state_next = ST_ADDR;
          end
        end
      endcase
    end
  end

  // Hold phase, count and position; take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_ADDR;
      station_address <= mrd_pkg::RESET_STATION;
      function_code   <= mrd_pkg::RESET_FUNCTION;
      length          <= 8'd0;
      position        <= 8'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          mrd_pkg::REG_STATION:  station_address <= cfg_data;
          mrd_pkg::REG_FUNCTION: function_code   <= cfg_data;
          default: ;
        endcase
      end
      if (accept && state == ST_COUNT) begin
        length   <= rx_byte;
        position <= 8'd0;
      end else if (accept && state == ST_PAYLOAD) begin
        position <= position_inc;
      end
    end
  end

endmodule

@@ sv/mrd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_queue: work queue between parser and checker
// A small circular buffer of command entries with a fill count.
// ----------------------------------------------------------------------------
module mrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mrd_pkg::entry_t wr_data,
  input  logic            rd_en,
  output mrd_pkg::entry_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrd_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Store a transfer into the tail slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ sv/mrd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_back: CRC checker and result stage
// Runs the CRC over each frame, works out the report kind and presents
// payload and verdict results in an output register.
// ----------------------------------------------------------------------------
module mrd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  mrd_pkg::entry_t q_data,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      payload_byte,
  output logic [7:0]      byte_index,
  output logic            is_verdict,
  output logic [1:0]      frame_status,
  output logic [1:0]      report_kind,
  output logic [7:0]      payload_length
);

  logic        out_valid;
  logic        out_free;
  logic        emits;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  length;
  logic [7:0]  first_payload;
  logic [7:0]  first_check;
  logic [1:0]  kind;
  logic [1:0]  kind_next;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign emits    = (q_data.cmd == mrd_pkg::CMD_PAYLOAD) ||
                    (q_data.cmd == mrd_pkg::CMD_CHK_HI);
  assign q_pop    = !q_empty && (!emits || out_free);

  // Byte-wise CRC; restart from all ones on a new address
  assign crc_next = mrd_pkg::crc_feed(
    (q_data.cmd == mrd_pkg::CMD_START) ? mrd_pkg::CRC_INIT : crc, q_data.data);

  // Settle the kind on the second payload byte
  always_comb begin
    kind_next = kind;
    if (q_data.cmd == mrd_pkg::CMD_PAYLOAD && q_data.index == 8'd1) begin
      if (q_data.data == mrd_pkg::SIG_SECOND && first_payload == mrd_pkg::SIG_ANCHOR) begin
        kind_next = mrd_pkg::KIND_ANCHOR;
      end else if (q_data.data == mrd_pkg::SIG_SECOND &&
                   first_payload == mrd_pkg::SIG_TAG) begin
        kind_next = mrd_pkg::KIND_TAG;
      end else begin
        kind_next = mrd_pkg::KIND_OTHER;
      end
    end
  end

  // Carry out each command; drop the result register once popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      crc           <= mrd_pkg::CRC_INIT;
      length        <= 8'd0;
      first_payload <= 8'd0;
      first_check   <= 8'd0;
      kind          <= mrd_pkg::KIND_OTHER;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_data.cmd) inside
          mrd_pkg::CMD_START, mrd_pkg::CMD_FUNC: begin
            crc <= crc_next;
          end
          mrd_pkg::CMD_COUNT: begin
            crc           <= crc_next;
            length        <= q_data.data;
            first_payload <= 8'd0;
            kind          <= mrd_pkg::KIND_OTHER;
          end
          mrd_pkg::CMD_PAYLOAD: begin
            crc <= crc_next;
            kind <= kind_next;
            if (q_data.index == 8'd0) begin
              first_payload <= q_data.data;
            end
            out_valid      <= 1'b1;
            payload_byte   <= q_data.data;
            byte_index     <= q_data.index;
            is_verdict     <= 1'b0;
            frame_status   <= mrd_pkg::STATUS_PENDING;
            report_kind    <= kind_next;
            payload_length <= length;
          end
          mrd_pkg::CMD_CHK_LO: begin
            first_check <= q_data.data;
          end
          mrd_pkg::CMD_CHK_HI: begin
            out_valid      <= 1'b1;
            payload_byte   <= 8'd0;
            byte_index     <= 8'd0;
            is_verdict     <= 1'b1;
            frame_status   <= (first_check == crc[7:0] && q_data.data == crc[15:8]) ?
                              mrd_pkg::STATUS_GOOD : mrd_pkg::STATUS_BAD;
            report_kind    <= kind;
            payload_length <= length;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sv/modbus_response_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_response_deframer: Modbus RTU response deframer with CRC-16 check
// Top level joining parser, work queue and CRC checker.
// ----------------------------------------------------------------------------
// Takes one received byte per clock when full is low. A byte that completes
// the address or function match, or belongs to the count, payload or check
// bytes, is passed through a QUEUE_DEPTH-entry work queue to the checker,
// which folds one whole byte into the CRC each cycle it is not stalled; a
// payload byte or the frame verdict is on the result ports from the edge
// after the one that took the byte when nothing is stalled. Sustained rate
// is one byte per cycle, set by the byte-wise CRC update; full rises only
// when pop is held low long enough to fill the queue and the result register.
// Registers may be written only while no frame bytes are in flight.
// ----------------------------------------------------------------------------
module modbus_response_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic       is_verdict,
  output logic [1:0] frame_status,
  output logic [1:0] report_kind,
  output logic [7:0] payload_length
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  mrd_pkg::entry_t q_wr;
  mrd_pkg::entry_t q_rd;

  assign full = q_full;

  mrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr)
  );

  mrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  mrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rd),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .is_verdict     (is_verdict),
    .frame_status   (frame_status),
    .report_kind    (report_kind),
    .payload_length (payload_length)
  );

  // Parser never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("work queue overflow");

  // Checker never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("work queue underflow");

  // A verdict carries a final status, a payload item carries pending
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (is_verdict ? (frame_status == mrd_pkg::STATUS_GOOD ||
                              frame_status == mrd_pkg::STATUS_BAD)
                           : (frame_status == mrd_pkg::STATUS_PENDING)))
    else $error("status does not match item type");

  // A verdict item holds no payload byte and index zero
  a_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_verdict) |-> (payload_byte == 8'd0 && byte_index == 8'd0))
    else $error("verdict item with payload data");

endmodule

@@ tb/sv/tb_modbus_response_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_response_deframer: self-checking bench for the response deframer
// Streams directed and random byte sequences (good, corrupted, truncated and
// noisy Modbus frames) through the push side under several station/function
// settings, predicts every payload item and verdict in step with each
// accepted byte, and compares each popped result field by field.
// ----------------------------------------------------------------------------
module tb_modbus_response_deframer;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_EVERY    = 180;

  // Payload shapes for built frames
  localparam int BODY_RANDOM = 0;
  localparam int BODY_ANCHOR = 1;
  localparam int BODY_TAG    = 2;
  localparam int BODY_NEAR   = 3;
  localparam int BODY_ZERO   = 4;
  localparam int BODY_ONES   = 5;

  typedef enum logic [2:0] {
    HUNT, AFTER_ADDR, READ_COUNT, READ_PAYLOAD, READ_CHK_LO, READ_CHK_HI
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] pb;
    logic [7:0] idx;
    logic       verdict;
    logic [1:0] status;
    logic [1:0] kind;
    logic [7:0] len;
  } deframe_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       cfg_we = 1'b0;
  logic       cfg_index = mrd_pkg::REG_STATION;
  logic [7:0] cfg_data = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       is_verdict;
  logic [1:0] frame_status;
  logic [1:0] report_kind;
  logic [7:0] payload_length;

  modbus_response_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .rx_byte       (rx_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .empty         (empty),
    .pop           (pop),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .is_verdict    (is_verdict),
    .frame_status  (frame_status),
    .report_kind   (report_kind),
    .payload_length(payload_length)
  );

  logic [7:0]      rx_pending[$];
  deframe_result_t deframe_expected[$];

  // Predictor copy of registers and parser state
  logic [7:0]   station_cfg  = mrd_pkg::RESET_STATION;
  logic [7:0]   function_cfg = mrd_pkg::RESET_FUNCTION;
  parse_phase_t ph           = HUNT;
  logic [15:0]  crc_acc      = mrd_pkg::CRC_INIT;
  logic [7:0]   count_seen   = 8'h00;
  logic [7:0]   pos          = 8'h00;
  logic [7:0]   chk_lo       = 8'h00;
  logic [7:0]   lead_byte    = 8'h00;
  logic [1:0]   kind_seen    = mrd_pkg::KIND_OTHER;

  logic steady     = 1'b0;
  logic drain_hold = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned bytes_taken  = 0;
  int unsigned items_popped = 0;
  int unsigned good_frames  = 0;
  int unsigned bad_frames   = 0;
  int unsigned idle_cycles  = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // CRC-16, one bit of the byte per shift, feedback from the low bit
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ mrd_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // Advance the parser copy by one accepted byte and queue what it yields
  task automatic predict_byte(input logic [7:0] b);
    deframe_result_t r;
    case (ph)
      AFTER_ADDR: begin
        if (b == function_cfg) begin
          crc_acc = crc16_fold(crc_acc, b);
          ph = READ_COUNT;
        end else if (b == station_cfg) begin
          crc_acc = crc16_fold(mrd_pkg::CRC_INIT, b);
          ph = AFTER_ADDR;
        end else begin
          ph = HUNT;
        end
      end
      READ_COUNT: begin
        crc_acc = crc16_fold(crc_acc, b);
        count_seen = b;
        pos = 8'h00;
        kind_seen = mrd_pkg::KIND_OTHER;
        lead_byte = 8'h00;
        ph = (b == 8'h00) ? READ_CHK_LO : READ_PAYLOAD;
      end
      READ_PAYLOAD: begin
        crc_acc = crc16_fold(crc_acc, b);
        if (pos == 8'd0) begin
          lead_byte = b;
        end else if (pos == 8'd1) begin
          if (b == mrd_pkg::SIG_SECOND && lead_byte == mrd_pkg::SIG_ANCHOR)
            kind_seen = mrd_pkg::KIND_ANCHOR;
          else if (b == mrd_pkg::SIG_SECOND && lead_byte == mrd_pkg::SIG_TAG)
            kind_seen = mrd_pkg::KIND_TAG;
          else kind_seen = mrd_pkg::KIND_OTHER;
        end
        r = '{pb: b, idx: pos, verdict: 1'b0, status: mrd_pkg::STATUS_PENDING,
              kind: kind_seen, len: count_seen};
        deframe_expected.push_back(r);
        pos = pos + 8'd1;
        if (pos == count_seen) ph = READ_CHK_LO;
      end
      READ_CHK_LO: begin
        chk_lo = b;
        ph = READ_CHK_HI;
      end
      READ_CHK_HI: begin
        r = '{pb: 8'h00, idx: 8'h00, verdict: 1'b1, status: mrd_pkg::STATUS_BAD,
              kind: kind_seen, len: count_seen};
        if (chk_lo == crc_acc[7:0] && b == crc_acc[15:8]) begin
          r.status = mrd_pkg::STATUS_GOOD;
          good_frames++;
        end else begin
          bad_frames++;
        end
        deframe_expected.push_back(r);
        ph = HUNT;
      end
      default: begin
        if (b == station_cfg) begin
          crc_acc = crc16_fold(mrd_pkg::CRC_INIT, b);
          ph = AFTER_ADDR;
        end else begin
          ph = HUNT;
        end
      end
    endcase
  endtask

  // Append one complete frame; optionally spoil a check byte
  task automatic build_frame(input logic [7:0] addr, input logic [7:0] fn, input int len,
                             input int body, input bit spoil);
    logic [15:0] crc;
    logic [7:0]  d;
    logic [7:0]  mask;
    crc = crc16_fold(mrd_pkg::CRC_INIT, addr);
    crc = crc16_fold(crc, fn);
    crc = crc16_fold(crc, len[7:0]);
    rx_pending.push_back(addr);
    rx_pending.push_back(fn);
    rx_pending.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      d = $urandom_range(255);
      case (body)
        BODY_ANCHOR: begin
          if (i == 0) d = mrd_pkg::SIG_ANCHOR;
          else if (i == 1) d = mrd_pkg::SIG_SECOND;
        end
        BODY_TAG: begin
          if (i == 0) d = mrd_pkg::SIG_TAG;
          else if (i == 1) d = mrd_pkg::SIG_SECOND;
        end
        BODY_NEAR: begin
          // one signature byte right, the other wrong
          if (i == 0) d = $urandom_range(1) ? mrd_pkg::SIG_ANCHOR : mrd_pkg::SIG_TAG;
          else if (i == 1) d = mrd_pkg::SIG_SECOND ^ (8'h01 << $urandom_range(7));
        end
        BODY_ZERO:   d = 8'h00;
        BODY_ONES:   d = 8'hFF;
        default: begin
          if (i == 1 && $urandom_range(3) == 0) d = mrd_pkg::SIG_SECOND;
        end
      endcase
      crc = crc16_fold(crc, d);
      rx_pending.push_back(d);
    end
    mask = spoil ? (8'h01 << $urandom_range(7)) | 8'($urandom_range(255)) : 8'h00;
    if ($urandom_range(1)) begin
      rx_pending.push_back(crc[7:0] ^ mask);
      rx_pending.push_back(crc[15:8]);
    end else begin
      rx_pending.push_back(crc[7:0]);
      rx_pending.push_back(crc[15:8] ^ mask);
    end
  endtask

  // Mostly well-formed frames, the rest broken openings and line noise
  task automatic add_random(input int n);
    int start;
    int len;
    int sel;
    start = rx_pending.size();
    while (rx_pending.size() - start < n) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12);
        build_frame(station_cfg, function_cfg, len, $urandom_range(BODY_ONES),
                    $urandom_range(3) == 0);
      end else if (sel < 80) begin
        // repeated address before a frame
        rx_pending.push_back(station_cfg);
        build_frame(station_cfg, function_cfg, $urandom_range(4), BODY_RANDOM,
                    $urandom_range(4) == 0);
      end else if (sel < 88) begin
        // address followed by a wrong function code
        rx_pending.push_back(station_cfg);
        rx_pending.push_back(8'($urandom_range(255)));
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          case ($urandom_range(3))
            0:       rx_pending.push_back(station_cfg);
            1:       rx_pending.push_back(function_cfg);
            default: rx_pending.push_back(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  // Wait until nothing is queued or in flight, then let the block settle
  task automatic drain_block();
    while (rx_pending.size() != 0 || push || deframe_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] st, input logic [7:0] fn);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mrd_pkg::REG_STATION;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= mrd_pkg::REG_FUNCTION;
    cfg_data  <= fn;
    @(posedge clk);
    cfg_we <= 1'b0;
    station_cfg  = st;
    function_cfg = fn;
    @(negedge clk);
  endtask

  // Driver: present pending bytes, predict each one at its transfer
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_byte(rx_byte);
        bytes_taken++;
        if (bytes_taken % DRAIN_EVERY == 0) drain_hold = 1'b1;
      end
      if (drain_hold && deframe_expected.size() == 0) drain_hold = 1'b0;
      if (push && full) begin
        // hold the stalled transfer
      end else if (rx_pending.size() != 0 && !drain_hold &&
                   (steady || $urandom_range(99) >= 35)) begin
        rx_byte <= rx_pending.pop_front();
        push    <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest prediction
  always @(posedge clk) begin
    deframe_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        items_popped++;
        if (deframe_expected.size() == 0) begin
          $error("result with nothing expected: byte %0h index %0d verdict %0b",
                 payload_byte, byte_index, is_verdict);
          mismatches++;
        end else begin
          want = deframe_expected.pop_front();
          if (payload_byte !== want.pb) begin
            $error("payload_byte expected %0h actual %0h", want.pb, payload_byte);
            mismatches++;
          end
          if (byte_index !== want.idx) begin
            $error("byte_index expected %0d actual %0d", want.idx, byte_index);
            mismatches++;
          end
          if (is_verdict !== want.verdict) begin
            $error("is_verdict expected %0b actual %0b", want.verdict, is_verdict);
            mismatches++;
          end
          if (frame_status !== want.status) begin
            $error("frame_status expected %0d actual %0d", want.status, frame_status);
            mismatches++;
          end
          if (report_kind !== want.kind) begin
            $error("report_kind expected %0d actual %0d", want.kind, report_kind);
            mismatches++;
          end
          if (payload_length !== want.len) begin
            $error("payload_length expected %0d actual %0d", want.len, payload_length);
            mismatches++;
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Watchdog: end the run when transfers stop on both sides
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, deframe_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: empty frame, anchor, spoilt tag, single byte, bad function
    build_frame(mrd_pkg::RESET_STATION, mrd_pkg::RESET_FUNCTION, 0, BODY_RANDOM, 1'b0);
    build_frame(mrd_pkg::RESET_STATION, mrd_pkg::RESET_FUNCTION, 3, BODY_ANCHOR, 1'b0);
    build_frame(mrd_pkg::RESET_STATION, mrd_pkg::RESET_FUNCTION, 2, BODY_TAG, 1'b1);
    build_frame(mrd_pkg::RESET_STATION, mrd_pkg::RESET_FUNCTION, 1, BODY_ONES, 1'b0);
    rx_pending.push_back(mrd_pkg::RESET_STATION);
    rx_pending.push_back(8'h07);
    drain_block();

    // Extreme settings: repeated address, mismatch, then random traffic
    set_regs(8'hFF, 8'h00);
    rx_pending.push_back(8'hFF);
    build_frame(8'hFF, 8'h00, 2, BODY_ZERO, 1'b0);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h11);
    add_random(170);
    drain_block();

    // Opposite extremes with no idling on either side
    set_regs(8'h00, 8'hFF);
    steady = 1'b1;
    add_random(170);
    drain_block();
    steady = 1'b0;

    // Address equal to function code, plus one full-length frame
    set_regs(8'h5A, 8'h5A);
    build_frame(8'h5A, 8'h5A, 2, BODY_NEAR, 1'b0);
    build_frame(8'h5A, 8'h5A, 255, BODY_RANDOM, 1'b0);
    add_random(170);
    drain_block();

    // Random settings
    for (int k = 0; k < 2; k++) begin
      set_regs(8'($urandom_range(255)), 8'($urandom_range(255)));
      add_random(100);
      drain_block();
    end

    $display("covered %0d bytes, %0d results popped, %0d good and %0d bad frames",
             bytes_taken, items_popped, good_frames, bad_frames);
    $display("settings: reset, FF/00, 00/FF, equal 5A, two random; %0d field errors",
             mismatches);
    if (mismatches == 0 && deframe_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
